// File: hw/rtl/psf_pkg.sv
package psf_pkg;

    // Start-code prefix 00 00 01 as it sits in the three-byte window.
    localparam logic [23:0] PREFIX_CODE  = 24'h000001;
    // Window contents right after a restart: no prefix possible.
    localparam logic [23:0] WINDOW_RESET = 24'hFFFFFF;
    // Stream id of a pack header.
    localparam logic [7:0]  PACK_ID      = 8'hBA;
    // Bytes that follow the id of a pack header.
    localparam logic [15:0] PACK_TAIL    = 16'd10;
    // Stuffing length field of the last pack header byte.
    localparam logic [7:0]  STUFF_MASK   = 8'h07;
    // Number of real bytes that make the window full.
    localparam logic [1:0]  WINDOW_FULL  = 2'd3;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Output byte slots of a packet start.
    localparam logic [1:0] SLOT_ZERO_A = 2'd0;
    localparam logic [1:0] SLOT_ZERO_B = 2'd1;
    localparam logic [1:0] SLOT_ONE    = 2'd2;
    localparam logic [1:0] SLOT_ID     = 2'd3;

    typedef enum logic {
        CMD_BYTE  = 1'b0,
        CMD_START = 1'b1
    } t_cmd_kind;

    // One command from the front: a single packet byte, or a packet start
    // that expands into the four bytes 00 00 01 id.
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic [7:0] id;
        logic       last;
        logic       resync;
    } t_cmd;

endpackage

// File: hw/rtl/program_stream_packet_framer.sv
// Channel   Direction  Handshake         Fields
// input     in         push / full       i_data_byte
// result    out        pop / empty       o_out_byte, o_stream_id, o_first_of_packet,
//                                        o_last_of_packet, o_resynced, o_last_in_run
//
// One input byte is taken per cycle while the four-entry command queue has room.
// A byte entry gives one result and a packet start gives four results, so the output
// register, one result per cycle while the result side is read, sets the rate.
// Synchronous active-low reset clears framing state, queue pointers and output valid.
// A stalled result side fills the queue and then raises full; input stalls
// simply let the queue and output drain.
module program_stream_packet_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic [7:0] o_stream_id,
    output logic       o_first_of_packet,
    output logic       o_last_of_packet,
    output logic       o_resynced,
    output logic       o_last_in_run
);

    logic          accept;
    logic          cmd_valid;
    psf_pkg::t_cmd cmd;
    psf_pkg::t_cmd head;
    logic          queue_empty;
    logic          head_pop;
    logic          out_valid;

    assign accept = push && !full;
    assign empty  = !out_valid;

    // Front: framing state machine, one transaction per cycle while the queue has room.
    psf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // Command queue between the two halves.
    psf_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd),
        .i_pop   (head_pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (queue_empty)
    );

    // Back: expands commands into result bytes.
    psf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head),
        .i_head_valid      (!queue_empty),
        .o_head_pop        (head_pop),
        .i_pop             (pop),
        .o_valid           (out_valid),
        .o_out_byte        (o_out_byte),
        .o_stream_id       (o_stream_id),
        .o_first_of_packet (o_first_of_packet),
        .o_last_of_packet  (o_last_of_packet),
        .o_resynced        (o_resynced),
        .o_last_in_run     (o_last_in_run)
    );

endmodule

// File: hw/rtl/psf_front.sv
module psf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    output logic          o_cmd_valid,
    output psf_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_LEN_HI = 5'b00010,
        PH_LEN_LO = 5'b00100,
        PH_BODY   = 5'b01000,
        PH_STUFF  = 5'b10000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [23:0] r_window, n_window;
    logic [1:0]  r_fill, n_fill;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_len_hi, n_len_hi;
    logic [7:0]  r_id, n_id;
    logic        r_pack, n_pack;
    logic        r_garbage, n_garbage;

    logic [15:0] len_full;
    logic [15:0] left_dec;
    logic [7:0]  stuff_cnt;

    assign len_full  = {r_len_hi, i_data_byte};
    assign left_dec  = r_left - 16'd1;
    assign stuff_cnt = i_data_byte & psf_pkg::STUFF_MASK;

    // Classify the byte and decide the next framing state.
    always_comb begin
        n_phase     = r_phase;
        n_window    = r_window;
        n_fill      = r_fill;
        n_left      = r_left;
        n_len_hi    = r_len_hi;
        n_id        = r_id;
        n_pack      = r_pack;
        n_garbage   = r_garbage;
        o_cmd_valid = 1'b0;
        o_cmd.kind   = psf_pkg::CMD_BYTE;
        o_cmd.data   = i_data_byte;
        o_cmd.id     = r_id;
        o_cmd.last   = 1'b0;
        o_cmd.resync = 1'b0;

        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (r_fill == psf_pkg::WINDOW_FULL &&
                            r_window == psf_pkg::PREFIX_CODE) begin
                        o_cmd_valid  = 1'b1;
                        o_cmd.kind   = psf_pkg::CMD_START;
                        o_cmd.id     = i_data_byte;
                        o_cmd.resync = r_garbage;
                        n_id         = i_data_byte;
                        n_pack       = (i_data_byte == psf_pkg::PACK_ID);
                        n_garbage    = 1'b0;
                        n_window     = psf_pkg::WINDOW_RESET;
                        n_fill       = 2'd0;
                        if (i_data_byte == psf_pkg::PACK_ID) begin
                            n_left  = psf_pkg::PACK_TAIL;
                            n_phase = PH_BODY;
                        end else begin
                            n_phase = PH_LEN_HI;
                        end
                    end else begin
                        if (r_fill == psf_pkg::WINDOW_FULL) begin
                            n_garbage = 1'b1;
                        end else begin
                            n_fill = r_fill + 2'd1;
                        end
                        n_window = {r_window[15:0], i_data_byte};
                    end
                end
                PH_LEN_HI: begin
                    o_cmd_valid = 1'b1;
                    n_len_hi    = i_data_byte;
                    n_phase     = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.last  = (len_full == 16'd0);
                    n_left      = len_full;
                    if (len_full == 16'd0) begin
                        n_phase  = PH_HUNT;
                        n_window = psf_pkg::WINDOW_RESET;
                        n_fill   = 2'd0;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    o_cmd_valid = 1'b1;
                    o_cmd.last  = (left_dec == 16'd0);
                    n_left      = left_dec;
                    if (left_dec == 16'd0) begin
                        if (r_pack && stuff_cnt != 8'd0) begin
                            n_left  = {8'd0, stuff_cnt};
                            n_phase = PH_STUFF;
                        end else begin
                            n_phase  = PH_HUNT;
                            n_window = psf_pkg::WINDOW_RESET;
                            n_fill   = 2'd0;
                        end
                    end
                end
                PH_STUFF: begin
                    n_left = left_dec;
                    if (left_dec == 16'd0) begin
                        n_phase  = PH_HUNT;
                        n_window = psf_pkg::WINDOW_RESET;
                        n_fill   = 2'd0;
                    end
                end
                default: begin
                    n_phase  = PH_HUNT;
                    n_window = psf_pkg::WINDOW_RESET;
                    n_fill   = 2'd0;
                end
            endcase
        end
    end

    // Framing state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_window  <= psf_pkg::WINDOW_RESET;
            r_fill    <= 2'd0;
            r_left    <= 16'd0;
            r_len_hi  <= 8'd0;
            r_id      <= 8'd0;
            r_pack    <= 1'b0;
            r_garbage <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_window  <= n_window;
            r_fill    <= n_fill;
            r_left    <= n_left;
            r_len_hi  <= n_len_hi;
            r_id      <= n_id;
            r_pack    <= n_pack;
            r_garbage <= n_garbage;
        end
    end

endmodule

// File: hw/rtl/psf_cmd_fifo.sv
module psf_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output psf_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_empty
);

    psf_pkg::t_cmd                    r_entries [psf_pkg::QUEUE_DEPTH];
    logic [psf_pkg::QUEUE_AW-1:0]     r_wr_ptr;
    logic [psf_pkg::QUEUE_AW-1:0]     r_rd_ptr;
    logic [psf_pkg::QUEUE_CW-1:0]     r_count;

    assign o_full  = (r_count == psf_pkg::QUEUE_CW'(psf_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entries[r_rd_ptr];

    // Storage; the front only pushes while the queue has room.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/psf_back.sv
module psf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  psf_pkg::t_cmd i_head,
    input  logic          i_head_valid,
    output logic          o_head_pop,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [7:0]    o_out_byte,
    output logic [7:0]    o_stream_id,
    output logic          o_first_of_packet,
    output logic          o_last_of_packet,
    output logic          o_resynced,
    output logic          o_last_in_run
);

    logic [1:0] r_slot;
    logic       r_valid;
    logic [7:0] r_byte;
    logic [7:0] r_id;
    logic       r_first;
    logic       r_last;
    logic       r_resync;
    logic       r_run_end;

    logic       load;
    logic       cmd_done;
    logic [7:0] n_byte;
    logic       n_first;
    logic       n_resync;

    // The output register takes a new result when it is free or being read.
    assign load       = i_head_valid && (!r_valid || i_pop);
    assign cmd_done   = (i_head.kind == psf_pkg::CMD_BYTE) || (r_slot == psf_pkg::SLOT_ID);
    assign o_head_pop = load && cmd_done;

    // Pick the byte of the current slot of a packet start.
    always_comb begin
        n_byte   = i_head.data;
        n_first  = 1'b0;
        n_resync = 1'b0;
        if (i_head.kind == psf_pkg::CMD_START) begin
            unique case (r_slot)
                psf_pkg::SLOT_ZERO_A: begin
                    n_byte   = 8'h00;
                    n_first  = 1'b1;
                    n_resync = i_head.resync;
                end
                psf_pkg::SLOT_ZERO_B: n_byte = 8'h00;
                psf_pkg::SLOT_ONE:    n_byte = 8'h01;
                default:              n_byte = i_head.id;
            endcase
        end
    end

    // Slot counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= psf_pkg::SLOT_ZERO_A;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_slot <= cmd_done ? psf_pkg::SLOT_ZERO_A : r_slot + 2'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= n_byte;
            r_id      <= i_head.id;
            r_first   <= n_first;
            r_last    <= (i_head.kind == psf_pkg::CMD_BYTE) && i_head.last;
            r_resync  <= n_resync;
            r_run_end <= cmd_done;
        end
    end

    assign o_valid           = r_valid;
    assign o_out_byte        = r_byte;
    assign o_stream_id       = r_id;
    assign o_first_of_packet = r_first;
    assign o_last_of_packet  = r_last;
    assign o_resynced        = r_resync;
    assign o_last_in_run     = r_run_end;

endmodule

// File: hw/rtl/psf_checker.sv
module psf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic [7:0] o_out_byte,
    input logic       o_first_of_packet,
    input logic       o_last_of_packet,
    input logic       o_resynced,
    input logic       o_last_in_run
);

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result offered after reset");

    // A packet opens with a zero byte and never ends its input run there.
    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_first_of_packet) |-> (o_out_byte == 8'h00 && !o_last_in_run))
        else $error("bad first byte of packet");

    // The resync flag appears only on the first byte of a packet.
    a_resync_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_resynced) |-> o_first_of_packet)
        else $error("resync flag off the first byte");

    // The last byte of a packet is always the last result of its input byte and never a packet's first byte.
    a_last_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_of_packet) |-> (o_last_in_run && !o_first_of_packet))
        else $error("packet end inside an input run");

endmodule

bind program_stream_packet_framer psf_checker u_psf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .empty             (empty),
    .o_out_byte        (o_out_byte),
    .o_first_of_packet (o_first_of_packet),
    .o_last_of_packet  (o_last_of_packet),
    .o_resynced        (o_resynced),
    .o_last_in_run     (o_last_in_run)
);
